// ===== design/lbo_pkg.sv =====
// Shared types, constants and helpers for the label boundary overlay block.
package lbo_pkg;

   localparam logic [31:0] WHITE_WORD = 32'h00ff_ffff;

   localparam int CSR_DATA_BITS = 12;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CFG_FRAME_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

   // neighborhood masks and output position flags, set by the front per slot
   typedef struct packed {
      logic b_top;
      logic b_bot;
      logic b_left;
      logic b_right;
      logic m_valid;
      logic m_top;
      logic m_bot;
      logic m_left;
      logic m_right;
      logic m_last;
   } ctl_type;

   localparam int CTL_BITS = 10;

   function automatic logic [31:0] clamp_fn(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
      logic [31:0] r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

endpackage

// ===== design/lbo_front.sv =====
// Front end: accepts items, tracks slot positions, drops early flushes, feeds the queue.
module lbo_front #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int LB = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           frame_abort,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_opcode,
   input  logic [15:0]                    req_label,
   input  logic [31:0]                    req_color,
   input  logic                           q_full,
   output logic                           q_push,
   output lbo_pkg::ctl_type               q_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]   q_ncol,
   output logic [$clog2(MAX_WIDTH)-1:0]   q_bcol,
   output logic [LB-1:0]                  q_label,
   output logic [31:0]                    q_color
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int YW = $clog2(MAX_HEIGHT+4);

   logic          fresh_ff, fresh_in;
   logic [XW-1:0] ncol_ff, ncol_in, bcol_ff, bcol_in, mcol_ff, mcol_in;
   logic [YW-1:0] nrow_ff, nrow_in, brow_ff, brow_in, mrow_ff, mrow_in;

   logic [XW-1:0] w_m1, w_m2, ncol_e, bcol_e, mcol_e;
   logic [YW-1:0] h_y, nrow_e, brow_e, mrow_e;
   logic          eof, n_in, accept;

   assign w_m1 = XW'(width - WW'(1));
   assign w_m2 = XW'(width - WW'(2));
   assign h_y  = YW'(height);

   // b runs w+1 slots behind, m runs 2w+2 behind; rows carry +2 / +3 offsets
   assign ncol_e = fresh_ff ? '0 : ncol_ff;
   assign nrow_e = fresh_ff ? '0 : nrow_ff;
   assign bcol_e = fresh_ff ? w_m1 : bcol_ff;
   assign brow_e = fresh_ff ? '0 : brow_ff;
   assign mcol_e = fresh_ff ? w_m2 : mcol_ff;
   assign mrow_e = fresh_ff ? '0 : mrow_ff;

   assign eof    = (nrow_e == h_y + YW'(2)) && (ncol_e == XW'(1));
   assign n_in   = nrow_e < h_y;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign q_push     = accept && !(req_opcode && n_in);

   always_comb begin
      ncol_in = (ncol_e == w_m1) ? '0 : ncol_e + XW'(1);
      nrow_in = (ncol_e == w_m1) ? nrow_e + YW'(1) : nrow_e;
      bcol_in = (bcol_e == w_m1) ? '0 : bcol_e + XW'(1);
      brow_in = (bcol_e == w_m1) ? brow_e + YW'(1) : brow_e;
      mcol_in = (mcol_e == w_m1) ? '0 : mcol_e + XW'(1);
      mrow_in = (mcol_e == w_m1) ? mrow_e + YW'(1) : mrow_e;
      fresh_in = eof;
   end

   always_comb begin
      q_ctl.b_top   = brow_e >= YW'(3);
      q_ctl.b_bot   = brow_e <= h_y;
      q_ctl.b_left  = bcol_e != '0;
      q_ctl.b_right = bcol_e != w_m1;
      q_ctl.m_valid = (mrow_e >= YW'(3)) && (mrow_e < h_y + YW'(3));
      q_ctl.m_top   = mrow_e >= YW'(4);
      q_ctl.m_bot   = mrow_e < h_y + YW'(2);
      q_ctl.m_left  = mcol_e != '0;
      q_ctl.m_right = mcol_e != w_m1;
      q_ctl.m_last  = (mrow_e == h_y + YW'(2)) && (mcol_e == w_m1);
   end

   assign q_ncol  = ncol_e;
   assign q_bcol  = bcol_e;
   assign q_label = req_label[LB-1:0];
   assign q_color = req_color;

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
         ncol_ff  <= '0;
         nrow_ff  <= '0;
         bcol_ff  <= '0;
         brow_ff  <= '0;
         mcol_ff  <= '0;
         mrow_ff  <= '0;
      end else if (frame_abort) begin
         fresh_ff <= 1'b1;
      end else if (q_push) begin
         fresh_ff <= fresh_in;
         ncol_ff  <= ncol_in;
         nrow_ff  <= nrow_in;
         bcol_ff  <= bcol_in;
         brow_ff  <= brow_in;
         mcol_ff  <= mcol_in;
         mrow_ff  <= mrow_in;
      end
   end

endmodule

// ===== design/lbo_queue.sv =====
// Small register FIFO between the front and the back.
module lbo_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CW'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
         if (do_pop) rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= din;
   end

endmodule

// ===== design/lbo_back.sv =====
// Back end: label line buffers, boundary test, flag line buffers, overlay and output register.
module lbo_back #(
   parameter int MAX_WIDTH = 2048,
   parameter int LB = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  lbo_pkg::ctl_type             q_ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0] q_ncol,
   input  logic [$clog2(MAX_WIDTH)-1:0] q_bcol,
   input  logic [LB-1:0]                q_label,
   input  logic [31:0]                  q_color,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [31:0]                  rsp_color,
   output logic                         rsp_boundary,
   output logic                         rsp_last
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int LW = LB + 32;

   // two rows of {label, color} and two rows of boundary flags
   logic [LW-1:0] line1_mem [MAX_WIDTH];
   logic [LW-1:0] line2_mem [MAX_WIDTH];
   logic          flag1_mem [MAX_WIDTH];
   logic          flag2_mem [MAX_WIDTH];

   logic en;
   logic b_vld_ff, c_vld_ff, rsp_vld_ff;

   // stage B
   lbo_pkg::ctl_type b_ctl_ff;
   logic [XW-1:0] b_ncol_ff, b_bcol_ff;
   logic [LB-1:0] b_label_ff;
   logic [31:0]   b_color_ff;
   logic [LW-1:0] rd_mid_ff, rd_top_ff;
   logic [LB-1:0] wl1_top_ff, wl1_mid_ff, wl1_bot_ff, wl2_top_ff, wl2_mid_ff, wl2_bot_ff;
   logic [31:0]   ctop1_ff, ctop2_ff;

   // stage C
   lbo_pkg::ctl_type c_ctl_ff;
   logic [XW-1:0] c_bcol_ff;
   logic          c_flag_ff, c_flag_in;
   logic [31:0]   c_color_ff;
   logic          fr_mid_ff, fr_top_ff;
   logic          fw1_top_ff, fw1_mid_ff, fw1_bot_ff, fw2_top_ff, fw2_mid_ff, fw2_bot_ff;

   logic [31:0]   rsp_color_ff, rsp_color_in;
   logic          rsp_boundary_ff, rsp_last_ff;

   logic [LB-1:0] r_top, r_mid, ctr;
   logic [7:0]    diff;
   logic          near;

   assign en    = !rsp_vld_ff || rsp_tready;
   assign q_pop = en && q_valid;

   // boundary test for the pixel at the center of the label window
   always_comb begin
      r_top = rd_top_ff[LW-1:32];
      r_mid = rd_mid_ff[LW-1:32];
      ctr   = wl1_mid_ff;
      diff[0] = b_ctl_ff.b_left && (wl2_mid_ff != ctr);
      diff[1] = b_ctl_ff.b_left && b_ctl_ff.b_top && (wl2_top_ff != ctr);
      diff[2] = b_ctl_ff.b_top && (wl1_top_ff != ctr);
      diff[3] = b_ctl_ff.b_right && b_ctl_ff.b_top && (r_top != ctr);
      diff[4] = b_ctl_ff.b_right && (r_mid != ctr);
      diff[5] = b_ctl_ff.b_right && b_ctl_ff.b_bot && (b_label_ff != ctr);
      diff[6] = b_ctl_ff.b_bot && (wl1_bot_ff != ctr);
      diff[7] = b_ctl_ff.b_left && b_ctl_ff.b_bot && (wl2_bot_ff != ctr);
      // more than one bit set
      c_flag_in = (diff & (diff - 8'd1)) != 8'd0;
   end

   always_comb begin
      near = (c_ctl_ff.m_left && fw2_mid_ff)
          || (c_ctl_ff.m_left && c_ctl_ff.m_top && fw2_top_ff)
          || (c_ctl_ff.m_top && fw1_top_ff)
          || (c_ctl_ff.m_right && c_ctl_ff.m_top && fr_top_ff)
          || (c_ctl_ff.m_right && fr_mid_ff)
          || (c_ctl_ff.m_right && c_ctl_ff.m_bot && c_flag_ff)
          || (c_ctl_ff.m_bot && fw1_bot_ff)
          || (c_ctl_ff.m_left && c_ctl_ff.m_bot && fw2_bot_ff);
      if (fw1_mid_ff) rsp_color_in = lbo_pkg::WHITE_WORD;
      else if (near) rsp_color_in = 32'd0;
      else rsp_color_in = c_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff   <= q_valid;
         c_vld_ff   <= b_vld_ff;
         rsp_vld_ff <= c_vld_ff && c_ctl_ff.m_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ctl_ff   <= q_ctl;
         b_ncol_ff  <= q_ncol;
         b_bcol_ff  <= q_bcol;
         b_label_ff <= q_label;
         b_color_ff <= q_color;
         rd_mid_ff  <= line1_mem[q_ncol];
         rd_top_ff  <= line2_mem[q_ncol];
         if (b_vld_ff) begin
            line1_mem[b_ncol_ff] <= {b_label_ff, b_color_ff};
            line2_mem[b_ncol_ff] <= rd_mid_ff;
            wl1_top_ff <= r_top;
            wl1_mid_ff <= r_mid;
            wl1_bot_ff <= b_label_ff;
            wl2_top_ff <= wl1_top_ff;
            wl2_mid_ff <= wl1_mid_ff;
            wl2_bot_ff <= wl1_bot_ff;
            ctop1_ff   <= rd_top_ff[31:0];
            ctop2_ff   <= ctop1_ff;
         end

         c_ctl_ff   <= b_ctl_ff;
         c_bcol_ff  <= b_bcol_ff;
         c_flag_ff  <= c_flag_in;
         c_color_ff <= ctop2_ff;
         fr_mid_ff  <= flag1_mem[b_bcol_ff];
         fr_top_ff  <= flag2_mem[b_bcol_ff];
         if (c_vld_ff) begin
            flag1_mem[c_bcol_ff] <= c_flag_ff;
            flag2_mem[c_bcol_ff] <= fr_mid_ff;
            fw1_top_ff <= fr_top_ff;
            fw1_mid_ff <= fr_mid_ff;
            fw1_bot_ff <= c_flag_ff;
            fw2_top_ff <= fw1_top_ff;
            fw2_mid_ff <= fw1_mid_ff;
            fw2_bot_ff <= fw1_bot_ff;
         end

         rsp_color_ff    <= rsp_color_in;
         rsp_boundary_ff <= fw1_mid_ff;
         rsp_last_ff     <= c_ctl_ff.m_last;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_color    = rsp_color_ff;
   assign rsp_boundary = rsp_boundary_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== design/label_boundary_overlay_top.sv =====
// Top level of the label boundary overlay block.
// Pixels stream in raster order, one per clock unless stalled; each result leaves
// 2*width+2 transactions after its pixel, via label line read, boundary test with flag
// line read and overlay register. Two rows of labels/colors and two rows of boundary flags
// sit in one-read one-write line memories of MAX_WIDTH entries; no clearing pass is needed.
// Flush transactions (tuser high) before the frame's last pixel are accepted and dropped;
// after it they drain the tail. A register write restarts the frame position.
module label_boundary_overlay_top #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int LABEL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // segment_label[15:0], pixel_color[47:16]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // color_out[31:0]
   output logic        rsp_tuser,   // is_boundary
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_wr_en,
   input  logic [lbo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lbo_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int HW = $clog2(MAX_HEIGHT+1);
   localparam int LB = (LABEL_BITS < 16) ? LABEL_BITS : 16;
   localparam int QW = lbo_pkg::CTL_BITS + 2*XW + LB + 32;
   localparam logic [WW-1:0] RESET_WIDTH =
      WW'(lbo_pkg::clamp_fn(32'd640, 32'd3, 32'(MAX_WIDTH)));
   localparam logic [HW-1:0] RESET_HEIGHT =
      HW'(lbo_pkg::clamp_fn(32'd480, 32'd1, 32'(MAX_HEIGHT)));

   logic [WW-1:0] frame_width_ff, frame_width_in;
   logic [HW-1:0] frame_height_ff, frame_height_in;

   logic             f_push, q_full, q_empty, q_pop;
   lbo_pkg::ctl_type f_ctl, q_ctl;
   logic [XW-1:0]    f_ncol, f_bcol, q_ncol, q_bcol;
   logic [LB-1:0]    f_label, q_label;
   logic [31:0]      f_color, q_color;
   logic [QW-1:0]    q_din, q_dout;

   assign frame_width_in  = WW'(lbo_pkg::clamp_fn(32'(csr_wr_data), 32'd3, 32'(MAX_WIDTH)));
   assign frame_height_in = HW'(lbo_pkg::clamp_fn(32'(csr_wr_data), 32'd1, 32'(MAX_HEIGHT)));

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_WIDTH;
         frame_height_ff <= RESET_HEIGHT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lbo_pkg::CFG_FRAME_WIDTH:  frame_width_ff  <= frame_width_in;
            lbo_pkg::CFG_FRAME_HEIGHT: frame_height_ff <= frame_height_in;
         endcase
      end
   end

   lbo_front #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .LB(LB)
   ) u_front (
      .clock(clock), .reset(reset), .frame_abort(csr_wr_en),
      .width(frame_width_ff), .height(frame_height_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_opcode(req_tuser), .req_label(req_tdata[15:0]), .req_color(req_tdata[47:16]),
      .q_full(q_full), .q_push(f_push), .q_ctl(f_ctl),
      .q_ncol(f_ncol), .q_bcol(f_bcol), .q_label(f_label), .q_color(f_color)
   );

   assign q_din = {f_ctl, f_ncol, f_bcol, f_label, f_color};
   assign {q_ctl, q_ncol, q_bcol, q_label, q_color} = q_dout;

   lbo_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock(clock), .reset(reset),
      .push(f_push), .din(q_din), .full(q_full),
      .pop(q_pop), .dout(q_dout), .empty(q_empty)
   );

   lbo_back #(.MAX_WIDTH(MAX_WIDTH), .LB(LB)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(!q_empty), .q_pop(q_pop), .q_ctl(q_ctl),
      .q_ncol(q_ncol), .q_bcol(q_bcol), .q_label(q_label), .q_color(q_color),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_color(rsp_tdata), .rsp_boundary(rsp_tuser), .rsp_last(rsp_tlast)
   );

endmodule

// ===== design/lbo_checker.sv =====
// Port-level checks for the label boundary overlay block, bound to the top level.
module lbo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_wr_en,
   input logic [lbo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [lbo_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   // no result may be pending right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a boundary pixel is always drawn white
   a_white: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == lbo_pkg::WHITE_WORD)
      else $error("boundary pixel not white");

endmodule

bind label_boundary_overlay_top lbo_checker u_lbo_checker (.*);

// ===== sim/tb_label_boundary_overlay_top.sv =====
// Self-checking testbench for label_boundary_overlay_top: directed and random frames against a line-store predictor.
`timescale 1ns / 100ps

module tb_label_boundary_overlay_top;

   typedef struct {
      bit          is_cfg;
      logic [lbo_pkg::CSR_INDEX_BITS-1:0] reg_idx;
      logic [lbo_pkg::CSR_DATA_BITS-1:0]  reg_val;
      logic        op;
      logic [15:0] label;
      logic [31:0] color;
   } pending_type;

   typedef struct {
      logic [31:0] color;
      logic        boundary;
      logic        last;
   } overlay_type;

   localparam int LINE_W = 2048;
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [47:0] req_tdata;      // segment_label[15:0], pixel_color[47:16]
   logic        rsp_tvalid, rsp_tready, rsp_tuser, rsp_tlast;
   logic [31:0] rsp_tdata;      // color_out[31:0]
   logic        csr_wr_en;
   logic [lbo_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [lbo_pkg::CSR_DATA_BITS-1:0]  csr_wr_data;

   label_boundary_overlay_top u_top (.*);

   pending_type stim_q[$];
   overlay_type overlay_q[$];
   pending_type held;
   int n_total, n_sent, n_rsp, n_errors, n_frames, idle_cnt, hold_left;
   bit hold_done;

   // predictor state
   logic [lbo_pkg::CSR_DATA_BITS-1:0] p_width, p_height;
   logic [15:0] lbl_mem [3*LINE_W];
   bit          bnd_mem [3*LINE_W];
   logic [31:0] col_mem [3*LINE_W];
   int pos_row, pos_col;

   function automatic int used_w();
      return (p_width < 3) ? 3 : ((p_width > LINE_W) ? LINE_W : int'(p_width));
   endfunction

   function automatic int used_h();
      return (p_height < 1) ? 1 : ((p_height > 2048) ? 2048 : int'(p_height));
   endfunction

   function automatic int slot(int y, int x);
      return (y % 3) * LINE_W + x;
   endfunction

   task automatic overlay_step(input logic op, input logic [15:0] lbl, input logic [31:0] col);
      int w, h, total, span, n, b, m, bx, by, mx, my, x, y, diff;
      bit self_b, near;
      int dx[8];
      int dy[8];
      overlay_type r;
      dx = '{-1, -1, 0, 1, 1, 1, 0, -1};
      dy = '{0, -1, -1, -1, 0, 1, 1, 1};
      w = used_w();
      h = used_h();
      total = w * h;
      span = total + 2 * w + 2;
      n = pos_row * w + pos_col;
      b = n - w - 1;
      m = n - 2 * w - 2;
      if (n < total && op == OP_FLUSH) return;
      if (n < total) lbl_mem[slot(pos_row, pos_col)] = lbl;
      if (b >= 0 && b < total) begin
         by = b / w;
         bx = b % w;
         diff = 0;
         for (int i = 0; i < 8; i++) begin
            x = bx + dx[i];
            y = by + dy[i];
            if (x >= 0 && x < w && y >= 0 && y < h && lbl_mem[slot(y, x)] != lbl_mem[slot(by, bx)])
               diff++;
         end
         bnd_mem[slot(by, bx)] = (diff > 1);
      end
      if (m >= 0 && m < total) begin
         my = m / w;
         mx = m % w;
         self_b = bnd_mem[slot(my, mx)];
         near = 0;
         for (int i = 0; i < 8; i++) begin
            x = mx + dx[i];
            y = my + dy[i];
            if (x >= 0 && x < w && y >= 0 && y < h && bnd_mem[slot(y, x)]) near = 1;
         end
         r.color = self_b ? lbo_pkg::WHITE_WORD : (near ? 32'd0 : col_mem[slot(my, mx)]);
         r.boundary = self_b;
         r.last = (m == total - 1);
         overlay_q.push_back(r);
      end
      if (n < total) col_mem[slot(pos_row, pos_col)] = col;
      if (n + 1 >= span) begin
         pos_row = 0;
         pos_col = 0;
         n_frames++;
      end else begin
         pos_col++;
         if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
         end
      end
   endtask

   task automatic add_cfg(input logic [lbo_pkg::CSR_INDEX_BITS-1:0] idx, input int val);
      pending_type p;
      p = '{default: '0};
      p.is_cfg = 1;
      p.reg_idx = idx;
      p.reg_val = lbo_pkg::CSR_DATA_BITS'(val);
      stim_q.push_back(p);
   endtask

   task automatic add_item(input logic op, input logic [15:0] lbl, input logic [31:0] col);
      pending_type p;
      p = '{default: '0};
      p.op = op;
      p.label = lbl;
      p.color = col;
      stim_q.push_back(p);
   endtask

   // one full frame plus tail; mode picks the label pattern
   task automatic add_frame(input int w, input int h, input int mode);
      logic [15:0] base, lbl;
      base = 16'($urandom);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(19) == 0) add_item(OP_FLUSH, 16'($urandom), $urandom);
         case (mode)
            0: lbl = 16'(base + $urandom_range(2));
            1: lbl = 16'($urandom);
            default: lbl = ($urandom_range(7) == 0) ? base ^ 16'h1 : base;
         endcase
         add_item(OP_PIXEL, lbl, $urandom);
      end
      for (int i = 0; i < 2 * w + 2; i++)
         add_item(($urandom_range(4) == 0) ? OP_PIXEL : OP_FLUSH, 16'($urandom), $urandom);
   endtask

   task automatic add_phase(input int wr, input int hr, input int frames);
      int w, h;
      add_cfg(lbo_pkg::CFG_FRAME_WIDTH, wr);
      add_cfg(lbo_pkg::CFG_FRAME_HEIGHT, hr);
      w = (wr < 3) ? 3 : ((wr > LINE_W) ? LINE_W : wr);
      h = (hr < 1) ? 1 : ((hr > 2048) ? 2048 : hr);
      for (int f = 0; f < frames; f++) add_frame(w, h, $urandom_range(2));
   endtask

   // start of a frame only; the next register write cuts it off
   task automatic add_partial(input int wr, input int hr, input int count);
      add_cfg(lbo_pkg::CFG_FRAME_WIDTH, wr);
      add_cfg(lbo_pkg::CFG_FRAME_HEIGHT, hr);
      for (int i = 0; i < count; i++) add_item(OP_PIXEL, 16'($urandom_range(1)), $urandom);
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      int rnd_items;
      reset = 1;
      // directed: clamped minimum frame, extreme labels and colors, early flush
      add_cfg(lbo_pkg::CFG_FRAME_WIDTH, 0);
      add_cfg(lbo_pkg::CFG_FRAME_HEIGHT, 0);
      add_item(OP_PIXEL, 16'h0000, 32'h0000_0000);
      add_item(OP_PIXEL, 16'hffff, 32'hffff_ffff);
      add_item(OP_FLUSH, 16'hffff, 32'hffff_ffff);
      add_item(OP_PIXEL, 16'h0000, 32'h1234_5678);
      for (int i = 0; i < 8; i++) add_item(i[0] ? OP_PIXEL : OP_FLUSH, 16'hffff, 32'hffff_ffff);
      // directed: 4x3 checkerboard
      add_cfg(lbo_pkg::CFG_FRAME_WIDTH, 4);
      add_cfg(lbo_pkg::CFG_FRAME_HEIGHT, 3);
      for (int i = 0; i < 12; i++)
         add_item(OP_PIXEL, ((i % 4) + (i / 4)) % 2 ? 16'hffff : 16'h0, 32'h8000_0001 << (i % 2));
      for (int i = 0; i < 10; i++) add_item(OP_FLUSH, 16'h0, 32'h0);
      rnd_items = 0;
      while (rnd_items < 750) begin
         int w, h, fr;
         w = $urandom_range(3, 9);
         h = $urandom_range(1, 7);
         fr = $urandom_range(1, 3);
         add_phase(w, h, fr);
         rnd_items += fr * (w * h + 2 * w + 2);
      end
      // register extremes on cut-off frames, then a medium frame
      add_partial(3, 4095, 40);
      add_partial(4095, 1, 10);
      add_phase(12, 10, 1);
      n_total = stim_q.size();
      repeat (10) @(posedge clock);
      reset <= 0;
      wait (stim_q.size() == 0 && !req_tvalid && overlay_q.size() == 0);
      repeat (30) @(posedge clock);
      $display("Covered %0d stimulus entries, %0d frames, %0d results checked.",
               n_total, n_frames, n_rsp);
      if (n_errors == 0 && overlay_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      int gap_pct;
      int idle_next;
      logic wr_now;
      gap_pct = (n_sent * 3 < n_total) ? 30 : ((n_sent * 3 < 2 * n_total) ? 49 : 0);
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= 0;
         csr_wr_en <= 0;
         csr_index <= '0;
         csr_wr_data <= '0;
         idle_cnt <= 0;
      end else begin
         wr_now = 1'b0;
         // counts quiet cycles: nothing offered and no result outstanding
         idle_next = (overlay_q.size() == 0 && !req_tvalid) ? idle_cnt + 1 : 0;
         if (req_tvalid && req_tready) overlay_step(held.op, held.label, held.color);
         if (!(req_tvalid && !req_tready)) begin
            if (stim_q.size() > 0 && stim_q[0].is_cfg) begin
               req_tvalid <= 0;
               if (!req_tvalid && idle_cnt >= 8) begin
                  wr_now = 1'b1;
                  csr_index <= stim_q[0].reg_idx;
                  csr_wr_data <= stim_q[0].reg_val;
                  if (stim_q[0].reg_idx == lbo_pkg::CFG_FRAME_WIDTH) p_width = stim_q[0].reg_val;
                  else p_height = stim_q[0].reg_val;
                  pos_row = 0;
                  pos_col = 0;
                  void'(stim_q.pop_front());
                  idle_next = 0;
               end
            end else if (stim_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
               held = stim_q.pop_front();
               req_tvalid <= 1;
               req_tuser <= held.op;
               req_tdata <= {held.color, held.label};
               n_sent++;
            end else begin
               req_tvalid <= 0;
            end
         end
         csr_wr_en <= wr_now;
         idle_cnt <= idle_next;
      end
   end

   // long receiver hold-off once, while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 0;
      end else if (!hold_done && stim_q.size() > 0 && stim_q.size() < 800) begin
         hold_left <= 3000;
         hold_done <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      int stall_pct;
      overlay_type e;
      stall_pct = (n_sent * 3 < n_total) ? 49 : ((n_sent * 3 < 2 * n_total) ? 30 : 0);
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (overlay_q.size() == 0) begin
               $error("unexpected result transaction, color_out %h", rsp_tdata);
               n_errors++;
            end else begin
               e = overlay_q.pop_front();
               if (rsp_tdata !== e.color) begin
                  $error("color_out: expected %h, got %h", e.color, rsp_tdata);
                  n_errors++;
               end
               if (rsp_tuser !== e.boundary) begin
                  $error("is_boundary: expected %b, got %b", e.boundary, rsp_tuser);
                  n_errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("frame_last: expected %b, got %b", e.last, rsp_tlast);
                  n_errors++;
               end
            end
         end
      end
   end

   initial begin
      p_width = 640;
      p_height = 480;
      pos_row = 0;
      pos_col = 0;
      n_sent = 0;
      n_rsp = 0;
      n_errors = 0;
      n_frames = 0;
   end

endmodule
